>>> rtl/link_reconnect_supervisor_unit_assert.svh
// ----------------------------------------------------------------------------
// Link reconnect supervisor assertion macros
// Shared property macros for the port checker of the supervisor unit.
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_SUPERVISOR_UNIT_ASSERT_SVH
`define LINK_RECONNECT_SUPERVISOR_UNIT_ASSERT_SVH

// Check a same-cycle implication, quiet during reset.
`define LRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, quiet during reset.
`define LRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// Link reconnect supervisor package
// Payload types, configuration layout, mode codes and reset values.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // Link mode codes
  localparam logic [1:0] MODE_OK    = 2'd0;
  localparam logic [1:0] MODE_RECON = 2'd1;
  localparam logic [1:0] MODE_WAIT  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RETRY_INTERVAL = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS   = 2'd1;
  localparam logic [1:0] REG_MAX_RESTARTS   = 2'd2;
  localparam logic [1:0] REG_WAIT_DURATION  = 2'd3;

  // Configuration reset values
  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd5000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd5;
  localparam logic [7:0]  MAX_RESTARTS_RST   = 8'd3;
  localparam logic [31:0] WAIT_DURATION_RST  = 32'd300000;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic        link_up;
    logic [31:0] now_ms;
  } lrs_poll_t;

  typedef struct packed {
    logic [1:0] link_mode;
    logic       start_connect;
    logic       restart_request;
    logic [7:0] attempt_count;
    logic [7:0] fail_count;
    logic       fail_count_write;
  } lrs_result_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [31:0] wdata;
  } lrs_cfg_wr_t;

  typedef struct packed {
    logic [31:0] retry_interval;
    logic [7:0]  max_attempts;
    logic [7:0]  max_restarts;
    logic [31:0] wait_duration;
  } lrs_cfg_t;

  // Saturating 8-bit increment
  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
  endfunction

endpackage

>>> rtl/lrs_chan_if.sv
// ----------------------------------------------------------------------------
// Link reconnect supervisor channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lrs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/lrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Link reconnect supervisor configuration registers
// Decode configuration writes into the four supervisor limits.
// ----------------------------------------------------------------------------
module lrs_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  lrs_pkg::lrs_cfg_wr_t wr,
  output lrs_pkg::lrs_cfg_t   cfg
);
  import lrs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_interval <= RETRY_INTERVAL_RST;
      cfg.max_attempts   <= MAX_ATTEMPTS_RST;
      cfg.max_restarts   <= MAX_RESTARTS_RST;
      cfg.wait_duration  <= WAIT_DURATION_RST;
    end else if (wr_en) begin
      unique case (wr.reg_index)
        REG_RETRY_INTERVAL: cfg.retry_interval <= wr.wdata;
        REG_MAX_ATTEMPTS:   cfg.max_attempts   <= wr.wdata[7:0];
        REG_MAX_RESTARTS:   cfg.max_restarts   <= wr.wdata[7:0];
        REG_WAIT_DURATION:  cfg.wait_duration  <= wr.wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/lrs_core.sv
// ----------------------------------------------------------------------------
// Link reconnect supervisor core
// Mode state, counters and timestamps, with the per-poll update logic.
// ----------------------------------------------------------------------------
module lrs_core (
  input  logic                 clk,
  input  logic                 rst,
  input  lrs_pkg::lrs_cfg_t    cfg,
  input  logic                 step_en,
  input  lrs_pkg::lrs_poll_t   poll,
  output lrs_pkg::lrs_result_t res
);
  import lrs_pkg::*;

  logic [1:0]  mode;
  logic [7:0]  attempts;
  logic [31:0] last_attempt_time;
  logic [31:0] wait_start_time;
  logic [7:0]  restart_failures;

  logic [1:0]  mode_next;
  logic [7:0]  attempts_next;
  logic [31:0] last_attempt_time_next;
  logic [31:0] wait_start_time_next;
  logic [7:0]  restart_failures_next;

  logic [31:0] since_attempt;
  logic [31:0] since_wait;
  logic [7:0]  attempts_inc;
  logic [7:0]  failures_inc;
  logic        connect;
  logic        restart;
  logic        persist;

  assign since_attempt = poll.now_ms - last_attempt_time;
  assign since_wait    = poll.now_ms - wait_start_time;
  assign attempts_inc  = sat_inc8(attempts);
  assign failures_inc  = sat_inc8(restart_failures);

  always_comb begin
    mode_next              = mode;
    attempts_next          = attempts;
    last_attempt_time_next = last_attempt_time;
    wait_start_time_next   = wait_start_time;
    restart_failures_next  = restart_failures;
    connect                = 1'b0;
    restart                = 1'b0;
    persist                = 1'b0;
    unique case (mode)
      MODE_OK: begin
        if (!poll.link_up) begin
          mode_next              = MODE_RECON;
          attempts_next          = '0;
          last_attempt_time_next = '0;
        end
      end
      MODE_WAIT: begin
        if (since_wait >= cfg.wait_duration) begin
          restart_failures_next = '0;
          persist               = 1'b1;
          connect               = 1'b1;
          mode_next             = MODE_RECON;
        end
      end
      default: begin
        // Reconnecting; the unused code behaves the same way
        mode_next = MODE_RECON;
        if (poll.link_up) begin
          restart_failures_next = '0;
          persist               = 1'b1;
          mode_next             = MODE_OK;
        end else if (since_attempt >= cfg.retry_interval) begin
          last_attempt_time_next = poll.now_ms;
          attempts_next          = attempts_inc;
          connect                = 1'b1;
          if (attempts_inc >= cfg.max_attempts) begin
            restart_failures_next = failures_inc;
            persist               = 1'b1;
            if (failures_inc >= cfg.max_restarts) begin
              mode_next            = MODE_WAIT;
              wait_start_time_next = poll.now_ms;
            end else begin
              restart       = 1'b1;
              attempts_next = '0;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_OK;
      attempts          <= '0;
      last_attempt_time <= '0;
      wait_start_time   <= '0;
      restart_failures  <= '0;
    end else if (step_en) begin
      mode              <= mode_next;
      attempts          <= attempts_next;
      last_attempt_time <= last_attempt_time_next;
      wait_start_time   <= wait_start_time_next;
      restart_failures  <= restart_failures_next;
    end
  end

  assign res.link_mode        = mode_next;
  assign res.start_connect    = connect;
  assign res.restart_request  = restart;
  assign res.attempt_count    = attempts_next;
  assign res.fail_count       = restart_failures_next;
  assign res.fail_count_write = persist;

endmodule

>>> rtl/link_reconnect_supervisor_unit.sv
// ----------------------------------------------------------------------------
// Link reconnect supervisor unit
// Polls a link once per transaction and issues reconnect, restart and
// persist requests.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload         Notes
//  poll     in   lrs_poll_t      link flag and millisecond timestamp
//  result   out  lrs_result_t    one result transaction per poll
//  cfg      in   lrs_cfg_wr_t    register write, always ready
//
//  A new poll is taken every cycle unless a stalled result holds it back.
//  A poll passes through the poll register, then the result register.
//  The supervisor state updates in the same edge that loads the result.
//  A stalled result holds; the poll register fills behind it, then poll
//  ready drops until the result transaction completes.
//  Synchronous active-high reset returns to ok mode with counts cleared
//  and the configuration at its defaults.
// ----------------------------------------------------------------------------
module link_reconnect_supervisor_unit (
  input logic       clk,
  input logic       rst,
  lrs_chan_if.sink   poll,
  lrs_chan_if.source result,
  lrs_chan_if.sink   cfg
);
  import lrs_pkg::*;

  lrs_cfg_t    cfg_regs;
  lrs_poll_t   poll_q;
  logic        poll_vld;
  lrs_result_t step_res;
  lrs_result_t res_q;
  logic        res_vld;
  logic        advance;

  // Writes land at once; software must write only while idle, unchecked here.
  assign cfg.ready = 1'b1;

  lrs_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg.valid),
    .wr    (cfg.payload),
    .cfg   (cfg_regs)
  );

  // Advance the held poll when the result register is free or draining.
  assign advance    = poll_vld && (!res_vld || result.ready);
  assign poll.ready = !poll_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_vld <= 1'b0;
    end else if (poll.valid && poll.ready) begin
      poll_vld <= 1'b1;
    end else if (advance) begin
      poll_vld <= 1'b0;
    end
  end

  // Capture the poll payload on each accepted transaction.
  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      poll_q <= poll.payload;
    end
  end

  lrs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .step_en (advance),
    .poll    (poll_q),
    .res     (step_res)
  );

  // Result register: load on advance, drop once the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= 1'b1;
    end else if (result.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign result.valid   = res_vld;
  assign result.payload = res_q;

endmodule

>>> rtl/lrs_checker.sv
// ----------------------------------------------------------------------------
// Link reconnect supervisor checker
// Port-level properties of the supervisor unit, attached by bind.
// ----------------------------------------------------------------------------
`include "link_reconnect_supervisor_unit_assert.svh"

module lrs_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input lrs_pkg::lrs_result_t res
);
  import lrs_pkg::*;

  `LRS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
                   res_valid && $stable(res), "result changed while stalled")
  `LRS_ASSERT_IMP(a_mode_code, res_valid, res.link_mode <= MODE_WAIT,
                  "unused link mode reported")
  `LRS_ASSERT_IMP(a_restart_shape, res_valid && res.restart_request,
                  res.start_connect && res.fail_count_write &&
                  res.link_mode == MODE_RECON && res.attempt_count == 8'd0,
                  "restart request without failure strobe")
  `LRS_ASSERT_IMP(a_ok_clears_fail,
                  res_valid && res.fail_count_write && res.link_mode == MODE_OK,
                  res.fail_count == 8'd0, "link recovery did not clear failure count")

endmodule

bind link_reconnect_supervisor_unit lrs_checker u_lrs_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res       (result.payload)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link reconnect supervisor unit testbench
// Sends link polls through the valid/ready poll channel and predicts each
// result transaction with an in-bench supervisor. Directed tests cover the
// mode transitions, the zero and full-scale limits and timestamp wrap.
// Random traffic follows under changing idle profiles and settings.
// ----------------------------------------------------------------------------
module testbench;
  import lrs_pkg::*;

  // Allow this many cycles with no transaction on any channel.
  localparam int unsigned STALL_LIMIT    = 1000;
  // Pipeline depth is two; allow a margin before touching the settings.
  localparam int unsigned LATENCY_CYCLES = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrs_chan_if #(.payload_t(lrs_poll_t))   poll_ch ();
  lrs_chan_if #(.payload_t(lrs_result_t)) result_ch ();
  lrs_chan_if #(.payload_t(lrs_cfg_wr_t)) cfg_ch ();

  link_reconnect_supervisor_unit i_dut (
    .clk   (clk),
    .rst   (rst),
    .poll  (poll_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Supervisor predictor: settings, state and the expected results in flight
  // --------------------------------------------------------------------------
  logic [31:0] cfg_retry_ms     = RETRY_INTERVAL_RST;
  logic [7:0]  cfg_max_attempts = MAX_ATTEMPTS_RST;
  logic [7:0]  cfg_max_restarts = MAX_RESTARTS_RST;
  logic [31:0] cfg_wait_ms      = WAIT_DURATION_RST;

  logic [1:0]  sup_mode         = MODE_OK;
  logic [7:0]  sup_attempts     = 8'd0;
  logic [31:0] last_attempt_ms  = 32'd0;
  logic [31:0] wait_start_ms    = 32'd0;
  logic [7:0]  restart_failures = 8'd0;

  lrs_result_t pending_reports[$];
  int unsigned mismatch_count = 0;

  // Idle percentages of the poll sender and the result receiver.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  // Running millisecond clock for random polls.
  logic [31:0] sim_ms = 32'd0;

  function automatic logic [7:0] bump_count(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Advance the supervisor by one poll and return the result it reports.
  function automatic lrs_result_t supervise_poll(input lrs_poll_t p);
    lrs_result_t r;
    logic [31:0] elapsed;
    r = '0;
    case (sup_mode)
      MODE_OK: begin
        // A drop opens a fresh round; the first attempt waits for a later poll.
        if (!p.link_up) begin
          sup_mode        = MODE_RECON;
          sup_attempts    = 8'd0;
          last_attempt_ms = 32'd0;
        end
      end
      MODE_WAIT: begin
        elapsed = p.now_ms - wait_start_ms;
        if (elapsed >= cfg_wait_ms) begin
          // Wait over: clear failures, reconnect, keep the attempt count.
          restart_failures   = 8'd0;
          r.fail_count_write = 1'b1;
          r.start_connect    = 1'b1;
          sup_mode           = MODE_RECON;
        end
      end
      default: begin
        sup_mode = MODE_RECON;
        elapsed  = p.now_ms - last_attempt_ms;
        if (p.link_up) begin
          restart_failures   = 8'd0;
          r.fail_count_write = 1'b1;
          sup_mode           = MODE_OK;
        end else if (elapsed >= cfg_retry_ms) begin
          last_attempt_ms = p.now_ms;
          sup_attempts    = bump_count(sup_attempts);
          r.start_connect = 1'b1;
          if (sup_attempts >= cfg_max_attempts) begin
            restart_failures   = bump_count(restart_failures);
            r.fail_count_write = 1'b1;
            if (restart_failures >= cfg_max_restarts) begin
              sup_mode      = MODE_WAIT;
              wait_start_ms = p.now_ms;
            end else begin
              // The restarted system comes back reconnecting with a new round.
              r.restart_request = 1'b1;
              sup_attempts      = 8'd0;
            end
          end
        end
      end
    endcase
    r.link_mode     = sup_mode;
    r.attempt_count = sup_attempts;
    r.fail_count    = restart_failures;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict on each poll transaction and
  // check each result transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lrs_result_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.payload.reg_index)
          REG_RETRY_INTERVAL: cfg_retry_ms     = cfg_ch.payload.wdata;
          REG_MAX_ATTEMPTS:   cfg_max_attempts = cfg_ch.payload.wdata[7:0];
          REG_MAX_RESTARTS:   cfg_max_restarts = cfg_ch.payload.wdata[7:0];
          REG_WAIT_DURATION:  cfg_wait_ms      = cfg_ch.payload.wdata;
          default: ;
        endcase
      end
      // Predict first so a result in the same edge can never miss its entry.
      if (poll_ch.valid && poll_ch.ready)
        pending_reports.push_back(supervise_poll(poll_ch.payload));
      if (result_ch.valid && result_ch.ready) begin
        if (pending_reports.size() == 0) begin
          $error("result transaction with no poll outstanding");
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("link_mode", 32'(want.link_mode),
                      32'(result_ch.payload.link_mode));
          check_field("start_connect", 32'(want.start_connect),
                      32'(result_ch.payload.start_connect));
          check_field("restart_request", 32'(want.restart_request),
                      32'(result_ch.payload.restart_request));
          check_field("attempt_count", 32'(want.attempt_count),
                      32'(result_ch.payload.attempt_count));
          check_field("fail_count", 32'(want.fail_count),
                      32'(result_ch.payload.fail_count));
          check_field("fail_count_write", 32'(want.fail_count_write),
                      32'(result_ch.payload.fail_count_write));
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  int unsigned stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL link_reconnect_supervisor_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: drop ready at random according to the current profile.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one poll; hold valid afterwards so back-to-back polls stream.
  task automatic send_poll(input logic up, input logic [31:0] t_ms);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap != 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid   <= 1'b1;
    poll_ch.payload <= '{link_up: up, now_ms: t_ms};
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
  endtask

  // Drop the poll stream and wait until every expected result has come.
  // Step the clock first so the last accepted poll is already predicted.
  task automatic settle_block();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{reg_index: idx, wdata: data};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Quiesce the block, then rewrite all four registers back to back.
  task automatic program_limits(input logic [31:0] retry_ms, input logic [7:0] attempts,
                                input logic [7:0] restarts, input logic [31:0] wait_ms);
    settle_block();
    write_reg(REG_RETRY_INTERVAL, retry_ms);
    write_reg(REG_MAX_ATTEMPTS, {24'd0, attempts});
    write_reg(REG_MAX_RESTARTS, {24'd0, restarts});
    write_reg(REG_WAIT_DURATION, wait_ms);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Mostly short intervals, with zero, full scale and anything now and then.
  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(1, 80);
    endcase
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 8'd255;
      1:       return 8'd1;
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  // Polls shaped by the predicted mode: steps near the interval in play, the
  // link mostly down while reconnecting, and an odd jump across the wrap.
  task automatic random_polls(input int n);
    logic        up;
    logic [31:0] step;
    logic [31:0] bound;
    int unsigned span;
    for (int i = 0; i < n; i++) begin
      case (sup_mode)
        MODE_OK:   up = ($urandom_range(0, 99) < 70);
        MODE_WAIT: up = 1'($urandom_range(0, 1));
        default:   up = ($urandom_range(0, 99) < 10);
      endcase
      bound = (sup_mode == MODE_WAIT) ? cfg_wait_ms : cfg_retry_ms;
      span  = (bound > 60) ? 60 : bound;
      case ($urandom_range(0, 9))
        0:       step = $urandom();
        1:       step = 32'd0;
        default: step = $urandom_range(0, 2 * span + 4);
      endcase
      sim_ms += step;
      send_poll(up, sim_ms);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: drop makes no attempt, then one attempt at the interval.
  task automatic test_reset_defaults();
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd4999);
    send_poll(1'b0, 32'd5000);
  endtask

  // Full cycle: attempts, restart, waiting, wait over, link back.
  task automatic test_restart_cycle();
    program_limits(32'd10, 8'd2, 8'd2, 32'd100);
    send_poll(1'b1, 32'd5001);  // link back while reconnecting
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd0);     // drop
    send_poll(1'b0, 32'd5);     // too early
    send_poll(1'b0, 32'd10);    // attempt one
    send_poll(1'b0, 32'd20);    // attempt limit, restart requested
    send_poll(1'b0, 32'd30);
    send_poll(1'b0, 32'd40);    // restart limit, enter waiting
    send_poll(1'b1, 32'd100);   // link flag ignored while waiting
    send_poll(1'b0, 32'd140);   // wait over, attempt count kept
    send_poll(1'b0, 32'd150);   // over the limit at once
    send_poll(1'b1, 32'd151);
  endtask

  // Elapsed time taken modulo 2^32 across the timestamp wrap.
  task automatic test_time_wrap();
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd5);
    send_poll(1'b0, 32'd9);
  endtask

  // Zero limits and intervals, then every setting at full scale.
  task automatic test_limit_extremes();
    program_limits(32'd0, 8'd0, 8'd0, 32'd0);
    send_poll(1'b0, 32'h8000_0000);  // failure at the first attempt, wait
    send_poll(1'b0, 32'h8000_0000);  // zero wait is over at once
    program_limits(32'hFFFF_FFFF, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'hFFFF_FFFE);
    send_poll(1'b0, 32'hFFFF_FFFE);
    send_poll(1'b0, 32'hFFFF_FFFF);
  endtask

  // Push the attempt count into saturation: every poll after the drop connects.
  task automatic test_count_saturation();
    program_limits(32'd0, 8'd255, 8'd1, 32'd0);
    send_poll(1'b1, $urandom());
    for (int i = 0; i < 260; i++) send_poll(1'b0, $urandom());
  endtask

  task automatic test_random_traffic();
    for (int s = 0; s < 3; s++) begin
      program_limits(pick_span(), pick_limit(), pick_limit(), pick_span());
      sim_ms = $urandom();
      random_polls(15);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    poll_ch.valid   <= 1'b0;
    poll_ch.payload <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.payload  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle(29, 62);
    test_reset_defaults();
    test_restart_cycle();
    test_time_wrap();
    test_limit_extremes();
    test_random_traffic();

    set_idle(62, 29);
    test_random_traffic();
    test_count_saturation();

    set_idle(0, 0);
    test_random_traffic();

    settle_block();
    if (mismatch_count == 0) begin
      $display("PASS link_reconnect_supervisor_unit");
    end else begin
      $display("FAIL link_reconnect_supervisor_unit");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lrs_pkg.sv
rtl/lrs_chan_if.sv
rtl/lrs_cfg_regs.sv
rtl/lrs_core.sv
rtl/link_reconnect_supervisor_unit.sv
rtl/lrs_checker.sv
bench/testbench.sv
